// ----- hdl/srrw_pkg.sv -----
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared widths and constants for the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int unsigned SEQ_W        = 5;   // sequence number field
  localparam int unsigned SLID_W       = 4;   // slid count field
  localparam int unsigned WSIZE_W      = 4;   // window_size register
  localparam int unsigned WSIZE_MAX    = 15;  // largest value the register can hold
  localparam int unsigned RANGE_FACTOR = 3;   // sequence range = 3 * window
  localparam int unsigned WSIZE_RESET  = 5;

endpackage

// ----- hdl/srrw_in_if.sv -----
// ----------------------------------------------------------------------------
// srrw_in_if
// Arriving sequence number channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srrw_in_if
  import srrw_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_num;

  modport source (output valid, output seq_num, input ready);
  modport sink   (input valid, input seq_num, output ready);
endinterface

// ----- hdl/srrw_out_if.sv -----
// ----------------------------------------------------------------------------
// srrw_out_if
// Window result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface srrw_out_if
  import srrw_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [SLID_W-1:0] slid_count;
  logic [SEQ_W-1:0]  head_seq;

  modport source (output valid, output accepted, output slid_count, output head_seq,
                  input ready);
  modport sink   (input valid, input accepted, input slid_count, input head_seq,
                  output ready);
endinterface

// ----- hdl/selective_repeat_rx_window_core.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_rx_window_core
// Receiver window of a selective-repeat link: marks arriving sequence
// numbers and slides the window while the head slot is received.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      seq_num[4:0]
//  out_ch   out  valid/ready      accepted, slid_count[3:0], head_seq[4:0]
//  cfg      in   cfg_we           cfg_wdata[3:0] = window_size
//
//  Each transaction runs from input accept through the slot scan, which compares
//  one slot a cycle, and the slide, where each slot slid uses the shared modular
//  adder twice (tail, then head); the result then waits for out_ch to be free.
//  in_ch.ready is high only while no item is in work; a waiting result does
//  not block the next input, only the hand-off of the following result.
//  Reset (rst_n low, synchronous) or a cfg write restores slot numbers to their
//  index, clears flags and zeroes the head.
// ----------------------------------------------------------------------------
module selective_repeat_rx_window_core
  import srrw_pkg::*;
#(
  parameter int unsigned WIN_MAX = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  srrw_in_if.sink            in_ch,
  srrw_out_if.source         out_ch,
  input  logic               cfg_we,
  input  logic [WSIZE_W-1:0] cfg_wdata
);

  localparam int unsigned WEFF    = (WIN_MAX < WSIZE_MAX) ? WIN_MAX : WSIZE_MAX;
  localparam int unsigned NUM_RAW = $clog2(RANGE_FACTOR * WEFF + 1);
  localparam int unsigned NUM_W   = (NUM_RAW > SEQ_W) ? NUM_RAW : SEQ_W;
  localparam int unsigned IDX_W   = (WIN_MAX > 1) ? $clog2(WIN_MAX) : 1;
  localparam int unsigned CW      = (IDX_W > WSIZE_W) ? IDX_W : WSIZE_W;
  localparam int unsigned WRST    = (WSIZE_RESET > WEFF) ? WEFF : WSIZE_RESET;

  typedef enum logic [2:0] {ST_IDLE, ST_SCAN, ST_SLIDE, ST_HEAD, ST_DONE} state_t;

  state_t             state_r;
  logic [WSIZE_W-1:0] w_r;
  logic [NUM_W-1:0]   range_r;
  logic [WIN_MAX-1:0] flags_r;
  logic [NUM_W-1:0]   nums_r [WIN_MAX];
  logic [NUM_W-1:0]   head_r;
  logic [NUM_W-1:0]   seq_r;
  logic [IDX_W-1:0]   idx_r;
  logic               acc_r;
  logic [SLID_W-1:0]  slid_r;

  logic               out_valid_r;
  logic               out_acc_r;
  logic [SLID_W-1:0]  out_slid_r;
  logic [SEQ_W-1:0]   out_head_r;

  logic [WSIZE_W-1:0] w_nxt;
  logic [NUM_W-1:0]   range_nxt;
  logic [NUM_W-1:0]   add_b;
  logic [NUM_W-1:0]   add_sum;
  logic               idx_last;
  logic               slot_hit;
  logic               out_free;
  logic [WIN_MAX-1:0] flags_sh;
  logic [NUM_W-1:0]   nums_sh [WIN_MAX];

  // clamp written window size to 1..WEFF
  always_comb begin
    w_nxt = cfg_wdata;
    if (cfg_wdata == '0) begin
      w_nxt = WSIZE_W'(1);
    end else if (cfg_wdata > WSIZE_W'(WEFF)) begin
      w_nxt = WSIZE_W'(WEFF);
    end
  end
  assign range_nxt = NUM_W'(w_nxt) + NUM_W'({w_nxt, 1'b0});

  // shared unit: tail = head + W in SLIDE, head + 1 in HEAD
  assign add_b = (state_r == ST_HEAD) ? NUM_W'(1) : NUM_W'(w_r);

  srrw_mod_add #(.NUM_W(NUM_W)) u_mod_add (
    .a     (head_r),
    .b     (add_b),
    .range (range_r),
    .sum   (add_sum)
  );

  assign idx_last = (CW'(idx_r) == (CW'(w_r) - CW'(1)));
  assign slot_hit = (nums_r[idx_r] == seq_r);
  assign out_free = !out_valid_r || out_ch.ready;

  // one-place shift toward the head inside the active window
  for (genvar j = 0; j < WIN_MAX; j++) begin : g_shift
    if (j < WIN_MAX - 1) begin : g_mid
      always_comb begin
        flags_sh[j] = flags_r[j];
        nums_sh[j]  = nums_r[j];
        if (CW'(j) < (CW'(w_r) - CW'(1))) begin
          flags_sh[j] = flags_r[j+1];
          nums_sh[j]  = nums_r[j+1];
        end else if (CW'(j) == (CW'(w_r) - CW'(1))) begin
          flags_sh[j] = 1'b0;
          nums_sh[j]  = add_sum;
        end
      end
    end else begin : g_last
      always_comb begin
        flags_sh[j] = flags_r[j];
        nums_sh[j]  = nums_r[j];
        if (CW'(j) == (CW'(w_r) - CW'(1))) begin
          flags_sh[j] = 1'b0;
          nums_sh[j]  = add_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      state_r <= ST_IDLE;
      flags_r <= '0;
      head_r  <= '0;
      idx_r   <= '0;
      acc_r   <= 1'b0;
      slid_r  <= '0;
      for (int i = 0; i < WIN_MAX; i++) begin
        nums_r[i] <= NUM_W'(i);
      end
      if (!rst_n) begin
        w_r         <= WSIZE_W'(WRST);
        range_r     <= NUM_W'(RANGE_FACTOR * WRST);
        out_valid_r <= 1'b0;
      end else begin
        w_r     <= w_nxt;
        range_r <= range_nxt;
        if (out_ch.ready) out_valid_r <= 1'b0;
      end
    end else begin
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            seq_r   <= NUM_W'(in_ch.seq_num);
            idx_r   <= '0;
            acc_r   <= 1'b0;
            slid_r  <= '0;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (slot_hit) begin
            flags_r[idx_r] <= 1'b1;
            acc_r          <= 1'b1;
          end
          if (idx_last) begin
            state_r <= ST_SLIDE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_SLIDE: begin
          if (slid_r < w_r && flags_r[0]) begin
            flags_r <= flags_sh;
            nums_r  <= nums_sh;
            state_r <= ST_HEAD;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_HEAD: begin
          head_r  <= add_sum;
          slid_r  <= slid_r + SLID_W'(1);
          state_r <= ST_SLIDE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_acc_r   <= acc_r;
            out_slid_r  <= slid_r;
            out_head_r  <= head_r[SEQ_W-1:0];
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.accepted   = out_acc_r;
  assign out_ch.slid_count = out_slid_r;
  assign out_ch.head_seq   = out_head_r;

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r < range_r)
    else $error("head number outside sequence range");

  a_slid_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    slid_r <= w_r)
    else $error("slide count exceeds window");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !cfg_we) |=> !in_ch.ready)
    else $error("input taken again while item in work");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (head_r == '0 && flags_r == '0))
    else $error("window not restarted after config write");

  a_result_slid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_slid_r <= w_r))
    else $error("result slid count exceeds window");

endmodule

// ----- hdl/srrw_mod_add.sv -----
// ----------------------------------------------------------------------------
// srrw_mod_add
// Modular adder: (a + b) mod range, valid for a, b below range.
// ----------------------------------------------------------------------------
module srrw_mod_add #(
  parameter int unsigned NUM_W = 5
) (
  input  logic [NUM_W-1:0] a,
  input  logic [NUM_W-1:0] b,
  input  logic [NUM_W-1:0] range,
  output logic [NUM_W-1:0] sum
);

  logic [NUM_W:0] raw;
  logic [NUM_W:0] wrapped;

  assign raw     = {1'b0, a} + {1'b0, b};
  assign wrapped = raw - {1'b0, range};
  assign sum     = (raw >= {1'b0, range}) ? wrapped[NUM_W-1:0] : raw[NUM_W-1:0];

endmodule

// ----- tb/selective_repeat_rx_window_core_tb.sv -----
// ----------------------------------------------------------------------------
// selective_repeat_rx_window_core_tb
// Drives arriving sequence numbers into the receive window. A local model of
// the slot flags, slot numbers and head tracks each accepted transaction and
// queues the expected result. Every result is checked against that queue.
// Covers directed corner cases, window size writes and random traffic with
// idling and backpressure on both sides.
// ----------------------------------------------------------------------------
module selective_repeat_rx_window_core_tb
  import srrw_pkg::*;
;

  localparam int unsigned WIN       = 8;
  localparam int unsigned SETTLE    = 40;
  localparam int unsigned HOLD_LEN  = 250;
  localparam int unsigned MAX_CYC   = 400000;
  localparam int unsigned IDLE_PCT  = 16;

  typedef struct packed {
    logic              accepted;
    logic [SLID_W-1:0] slid;
    logic [SEQ_W-1:0]  head;
  } win_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [WSIZE_W-1:0] cfg_wdata;

  srrw_in_if  in_ch ();
  srrw_out_if out_ch ();

  selective_repeat_rx_window_core #(
    .WIN_MAX (WIN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // local copy of the window
  logic                rx_flags [WIN];
  logic [SEQ_W-1:0]    rx_slots [WIN];
  logic [SEQ_W-1:0]    rx_head;
  int unsigned         rx_wsize;

  win_result_t pending_results[$];
  int unsigned err_count;
  int unsigned cycle_count;
  bit          idle_en;
  bit          hold_req;
  int unsigned hold_left;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // window model
  // --------------------------------------------------------------------------
  function automatic void clear_window();
    for (int i = 0; i < WIN; i++) begin
      rx_flags[i] = 1'b0;
      rx_slots[i] = SEQ_W'(i);
    end
    rx_head = '0;
  endfunction

  function automatic void load_wsize(logic [WSIZE_W-1:0] val);
    if (val == 0)
      rx_wsize = 1;
    else if (val > WIN)
      rx_wsize = WIN;
    else
      rx_wsize = 32'(val);
    clear_window();
  endfunction

  function automatic win_result_t advance_window(logic [SEQ_W-1:0] seq);
    win_result_t res;
    int unsigned rng;
    int unsigned tail;
    int unsigned slid;
    int unsigned nxt;
    rng = rx_wsize * RANGE_FACTOR;
    slid = 0;
    res.accepted = 1'b0;
    for (int j = 0; j < rx_wsize; j++) begin
      if (rx_slots[j] == seq) begin
        rx_flags[j]  = 1'b1;
        res.accepted = 1'b1;
      end
    end
    while (slid < rx_wsize && rx_flags[0]) begin
      for (int j = 0; j + 1 < rx_wsize; j++) begin
        rx_flags[j] = rx_flags[j+1];
        rx_slots[j] = rx_slots[j+1];
      end
      tail = rx_head + rx_wsize;
      if (tail >= rng)
        tail -= rng;
      rx_flags[rx_wsize-1] = 1'b0;
      rx_slots[rx_wsize-1] = SEQ_W'(tail);
      nxt = rx_head + 1;
      rx_head = (nxt >= rng) ? '0 : SEQ_W'(nxt);
      slid++;
    end
    res.slid = SLID_W'(slid);
    res.head = rx_head;
    return res;
  endfunction

  // mostly numbers inside the window, some just outside it, some anything
  function automatic logic [SEQ_W-1:0] pick_seq();
    int unsigned rng;
    int unsigned r;
    rng = rx_wsize * RANGE_FACTOR;
    r = $urandom_range(99);
    if (r < 80)
      return SEQ_W'((rx_head + $urandom_range(rx_wsize - 1)) % rng);
    else if (r < 92)
      return SEQ_W'((rx_head + $urandom_range(3 * rx_wsize - 1, rx_wsize)) % rng);
    else
      return SEQ_W'($urandom_range(31));
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers; all entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_seq(input logic [SEQ_W-1:0] seq);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.seq_num <= seq;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    pending_results = {pending_results, advance_window(seq)};
    @(negedge clk);
  endtask

  task automatic stop_send();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_window(input logic [WSIZE_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    load_wsize(val);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_seq(pick_seq());
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_in_order();
    send_seq(5'd0);
    send_seq(5'd1);
    send_seq(5'd2);
    stop_send();
  endtask

  // head at 3: a gap, then the hole filled; then a whole window in reverse
  task automatic test_out_of_order();
    send_seq(5'd4);
    send_seq(5'd3);
    send_seq(5'd9);
    send_seq(5'd8);
    send_seq(5'd7);
    send_seq(5'd6);
    send_seq(5'd5);
    stop_send();
  endtask

  // head at 10
  task automatic test_duplicates();
    send_seq(5'd12);
    send_seq(5'd12);
    send_seq(5'd11);
    send_seq(5'd10);
    stop_send();
  endtask

  // head at 13, window 13,14,0,1,2 wraps through the range
  task automatic test_outside_window();
    send_seq(5'd5);
    send_seq(5'd31);
    send_seq(5'd15);
    send_seq(5'd20);
    send_seq(5'd0);
    send_seq(5'd1);
    send_seq(5'd13);
    send_seq(5'd14);
    stop_send();
  endtask

  task automatic test_window_sizes();
    set_window(4'd0);              // used as 1
    send_seq(5'd0);
    send_seq(5'd3);
    send_seq(5'd1);
    send_seq(5'd2);
    send_seq(5'd0);
    stop_send();
    set_window(4'd15);             // used as the maximum
    send_seq(5'd23);
    send_seq(5'd16);
    for (int i = WIN - 1; i >= 0; i--)
      send_seq(SEQ_W'(i));
    stop_send();
  endtask

  task automatic test_random_traffic();
    logic [WSIZE_W-1:0] sizes [10];
    sizes = '{4'd1, 4'd8, 4'd2, 4'd9, 4'd3, 4'd4, 4'd12, 4'd6, 4'd7, 4'd5};
    foreach (sizes[k]) begin
      set_window(sizes[k]);
      send_random(85);
      stop_send();
    end
  endtask

  task automatic test_no_idle_burst();
    set_window(4'd8);
    idle_en = 1'b0;
    send_random(150);
    stop_send();
    idle_en = 1'b1;
  endtask

  // receiver stalls for a long stretch while items keep coming
  task automatic test_receiver_hold();
    set_window(4'd3);
    hold_req = 1'b1;
    send_random(40);
    stop_send();
  endtask

  // sender stops mid-stream until every result is back, then resumes
  task automatic test_sender_pause();
    set_window(4'd7);
    send_random(20);
    stop_send();
    while (pending_results.size() != 0)
      @(negedge clk);
    send_random(20);
    stop_send();
  endtask

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    win_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected result: acc=%0b slid=%0d head=%0d",
                   out_ch.accepted, out_ch.slid_count, out_ch.head_seq);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_ch.accepted !== exp_res.accepted || out_ch.slid_count !== exp_res.slid ||
            out_ch.head_seq !== exp_res.head) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp acc=%0b slid=%0d head=%0d, got acc=%0b slid=%0d head=%0d",
                     exp_res.accepted, exp_res.slid, exp_res.head,
                     out_ch.accepted, out_ch.slid_count, out_ch.head_seq);
        end
      end
    end
  end

  // receiver ready, with random idling and a counted hold-off
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYC) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** selective_repeat_rx_window_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.seq_num = '0;
    err_count     = 0;
    cycle_count   = 0;
    idle_en       = 1'b1;
    hold_req      = 1'b0;
    load_wsize(WSIZE_W'(WSIZE_RESET));
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_in_order();
    test_out_of_order();
    test_duplicates();
    test_outside_window();
    test_window_sizes();
    test_random_traffic();
    test_no_idle_burst();
    test_receiver_hold();
    test_sender_pause();

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("** selective_repeat_rx_window_core: PASSED **");
    end else begin
      $display("** selective_repeat_rx_window_core: FAILED **");
    end
    $finish;
  end

endmodule
